FILE: rtl/adq_pkg.sv
// Shared types and constants of the adaptive differential dequantizer.
`timescale 1ns / 1ps

package adq_pkg;

	localparam int CODE_W     = 16;
	localparam int STEP_W     = 15;
	localparam int SUM_W      = 20;
	localparam int VG_W       = 15;
	localparam int PG_W       = 16;
	localparam int WL_W       = 5;
	localparam int TGT_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_MAX_WINDOW = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_VARIANCE_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREDICTOR_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd2;

	localparam logic [VG_W-1:0]   VG_RESET   = 15'd16384;
	localparam logic [PG_W-1:0]   PG_RESET   = 16'd0;
	localparam logic [WL_W-1:0]   WL_RESET   = 5'd10;
	localparam logic [STEP_W-1:0] STEP_MAX   = 15'd32766;
	localparam logic [STEP_W-1:0] STEP_RESET = 15'd1;

	// Commands from the controller to the datapath, one per sequencer step.
	typedef struct packed {
		logic load;    // capture the accepted codes
		logic mul;     // code * step and gain * previous output
		logic upd;     // output, prediction, window and sum update
		logic tgt;     // step target product, loads the divider
		logic div;     // one quotient bit of target / length
		logic commit;  // new step, window advance, result register load
	} cmd_t;

endpackage

FILE: rtl/adq_in_if.sv
// Input channel: one word of two quantized codes.
`timescale 1ns / 1ps

interface adq_in_if;
	import adq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CODE_W-1:0] code_left;
	logic signed [CODE_W-1:0] code_right;

	modport source (output valid, output code_left, output code_right, input ready);
	modport sink (input valid, input code_left, input code_right, output ready);
endinterface

FILE: rtl/adq_out_if.sv
// Output channel: one word of two reconstructed samples.
`timescale 1ns / 1ps

interface adq_out_if;
	import adq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [CODE_W-1:0] out_left;
	logic signed [CODE_W-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink (input valid, input out_left, input out_right, output ready);
endinterface

FILE: rtl/adaptive_differential_dequantizer_unit.sv
// Top level of the stereo adaptive differential dequantizer.
`timescale 1ns / 1ps

// Each input word carries one code per channel and yields one output word with one
// reconstructed sample per channel. An accepted word goes through the multiply, state
// update and step target steps, then a 17-step restoring division of the step target by
// the window length, one quotient bit per cycle; both channels run their own divider side
// by side. No new word is accepted until the result is committed to the output register,
// and the commit waits while the previous result still waits there. A finished word waits
// in the output register, and the next word is accepted while it waits. The magnitude
// windows sit in small memories whose per-entry valid bits reset clears at once, so the
// block is ready right after reset with no clearing pass. The user must write configuration
// through wr_en/wr_index/wr_data only while no word is in flight; the block does not enforce it.
module adaptive_differential_dequantizer_unit #(
	parameter int MAX_WINDOW = adq_pkg::DEF_MAX_WINDOW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	adq_in_if.sink                         codes,
	adq_out_if.source                      samples,
	input  logic                           wr_en,
	input  logic [adq_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [adq_pkg::CFG_DATA_W-1:0] wr_data
);
	import adq_pkg::*;

	cmd_t cmd;

	adq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (codes.valid),
		.in_ready  (codes.ready),
		.out_valid (samples.valid),
		.out_ready (samples.ready),
		.cmd       (cmd)
	);

	adq_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.code_left  (codes.code_left),
		.code_right (codes.code_right),
		.out_left   (samples.out_left),
		.out_right  (samples.out_right)
	);

	// An accepted word starts the sequence and blocks further input.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(codes.valid && codes.ready) |=> (cmd.mul && !codes.ready))
		else $error("accepted word did not start the sequence");

	// A result never overwrites a word that is still waiting at the output.
	a_commit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!samples.valid || samples.ready))
		else $error("result register overwritten while occupied");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> samples.valid)
		else $error("committed word not offered at the output");

	// The update step always follows the multiply step.
	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> $past(cmd.mul))
		else $error("update without preceding multiply");

endmodule

FILE: rtl/adq_lane.sv
// One channel of the datapath: state, magnitude window, multipliers and step divider.
`timescale 1ns / 1ps

module adq_lane #(
	parameter int MAX_WINDOW = adq_pkg::DEF_MAX_WINDOW,
	parameter int LEN_W      = $clog2(MAX_WINDOW + 1),
	parameter int POS_W      = $clog2(MAX_WINDOW)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  adq_pkg::cmd_t                    cmd,
	input  logic signed [adq_pkg::CODE_W-1:0] code,
	input  logic [adq_pkg::VG_W-1:0]         vg,
	input  logic signed [adq_pkg::PG_W-1:0]  pg,
	input  logic [LEN_W-1:0]                 len,
	input  logic [POS_W-1:0]                 pos,
	output logic signed [adq_pkg::CODE_W-1:0] sample
);
	import adq_pkg::*;

	logic signed [CODE_W-1:0] code_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [CODE_W-1:0] pred_q;
	logic signed [CODE_W-1:0] last_q;
	logic [SUM_W-1:0]         sum_q;
	logic [MAX_WINDOW-1:0]    vld_q;
	logic [CODE_W-1:0]        win_mem [MAX_WINDOW];
	logic [CODE_W-1:0]        rd_q;
	logic                     rd_vld_q;
	logic signed [CODE_W-1:0] diff_q;
	logic signed [31:0]       prod_q;
	logic [TGT_W-1:0]         dvd_q;
	logic [LEN_W-1:0]         rem_q;

	logic signed [31:0]       mul_w;
	logic signed [31:0]       bias_w;
	logic [CODE_W-1:0]        q_w;
	logic signed [CODE_W-1:0] out_w;
	logic signed [CODE_W-1:0] pred_w;
	logic [CODE_W-1:0]        mag_w;
	logic [SUM_W-1:0]         sum_w;
	logic [34:0]              tprod_w;
	logic [LEN_W:0]           shl_w;
	logic                     ge_w;
	logic [LEN_W:0]           sub_w;
	logic [STEP_W-1:0]        step_w;

	always_comb begin
		mul_w  = code_q * $signed({1'b0, step_q});
		// Truncating division by 32768: bias negative products before the shift.
		bias_w = prod_q + (prod_q[31] ? 32'sd32767 : 32'sd0);
		q_w    = bias_w[30:15];
		out_w  = diff_q + pred_q;
		pred_w = out_w - $signed(q_w);
		mag_w  = diff_q[CODE_W-1] ? (~diff_q + 16'd1) : diff_q;
		sum_w  = sum_q - (rd_vld_q ? SUM_W'(rd_q) : '0) + SUM_W'(mag_w);
		tprod_w = 35'(sum_q) * 35'(vg);
		shl_w  = {rem_q, dvd_q[TGT_W-1]};
		ge_w   = shl_w >= {1'b0, len};
		sub_w  = shl_w - {1'b0, len};
		if (dvd_q > TGT_W'(STEP_MAX)) begin
			step_w = STEP_MAX;
		end else if (dvd_q == '0) begin
			step_w = STEP_RESET;
		end else begin
			step_w = dvd_q[STEP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			pred_q <= '0;
			last_q <= '0;
			sum_q  <= '0;
			vld_q  <= '0;
		end else begin
			if (cmd.upd) begin
				pred_q     <= pred_w;
				last_q     <= out_w;
				sum_q      <= sum_w;
				vld_q[pos] <= 1'b1;
			end
			if (cmd.commit) begin
				step_q <= step_w;
			end
		end
	end

	// Window memory: one read and one write port, registered read.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rd_q <= win_mem[pos];
		end
		if (cmd.upd) begin
			win_mem[pos] <= mag_w;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= code;
		end
		if (cmd.mul) begin
			diff_q   <= mul_w[CODE_W-1:0];
			prod_q   <= pg * last_q;
			rd_vld_q <= vld_q[pos];
		end
		if (cmd.tgt) begin
			dvd_q <= tprod_w[31:15];
			rem_q <= '0;
		end else if (cmd.div) begin
			dvd_q <= {dvd_q[TGT_W-2:0], ge_w};
			rem_q <= ge_w ? sub_w[LEN_W-1:0] : shl_w[LEN_W-1:0];
		end
	end

	assign sample = last_q;

endmodule

FILE: rtl/adq_dp.sv
// Datapath: configuration registers, window position, both channel lanes and result register.
`timescale 1ns / 1ps

module adq_dp #(
	parameter int MAX_WINDOW = adq_pkg::DEF_MAX_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  adq_pkg::cmd_t                       cmd,
	input  logic                                wr_en,
	input  logic [adq_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [adq_pkg::CFG_DATA_W-1:0]      wr_data,
	input  logic signed [adq_pkg::CODE_W-1:0]   code_left,
	input  logic signed [adq_pkg::CODE_W-1:0]   code_right,
	output logic signed [adq_pkg::CODE_W-1:0]   out_left,
	output logic signed [adq_pkg::CODE_W-1:0]   out_right
);
	import adq_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int POS_W = $clog2(MAX_WINDOW);

	logic [VG_W-1:0]          vg_q;
	logic signed [PG_W-1:0]   pg_q;
	logic [WL_W-1:0]          wl_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [CODE_W-1:0] res_left_q;
	logic signed [CODE_W-1:0] res_right_q;

	logic [LEN_W-1:0]         len_w;
	logic [POS_W:0]           pos_inc_w;
	logic signed [CODE_W-1:0] lane_left_w;
	logic signed [CODE_W-1:0] lane_right_w;

	// Effective length is the register clamped to one through the window depth.
	always_comb begin
		if (wl_q == '0) begin
			len_w = LEN_W'(1);
		end else if (int'(wl_q) > MAX_WINDOW) begin
			len_w = LEN_W'(MAX_WINDOW);
		end else begin
			len_w = LEN_W'(wl_q);
		end
		pos_inc_w = {1'b0, pos_q} + (POS_W + 1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vg_q  <= VG_RESET;
			pg_q  <= PG_RESET;
			wl_q  <= WL_RESET;
			pos_q <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					CFG_VARIANCE_GAIN:  vg_q <= wr_data[VG_W-1:0];
					CFG_PREDICTOR_GAIN: pg_q <= $signed(wr_data[PG_W-1:0]);
					CFG_WINDOW_LENGTH:  wl_q <= wr_data[WL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				pos_q <= (pos_inc_w >= (POS_W + 1)'(len_w)) ? '0 : pos_inc_w[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_left_q  <= lane_left_w;
			res_right_q <= lane_right_w;
		end
	end

	adq_lane #(
		.MAX_WINDOW (MAX_WINDOW),
		.LEN_W      (LEN_W),
		.POS_W      (POS_W)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.code   (code_left),
		.vg     (vg_q),
		.pg     (pg_q),
		.len    (len_w),
		.pos    (pos_q),
		.sample (lane_left_w)
	);

	adq_lane #(
		.MAX_WINDOW (MAX_WINDOW),
		.LEN_W      (LEN_W),
		.POS_W      (POS_W)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.code   (code_right),
		.vg     (vg_q),
		.pg     (pg_q),
		.len    (len_w),
		.pos    (pos_q),
		.sample (lane_right_w)
	);

	assign out_left  = res_left_q;
	assign out_right = res_right_q;

endmodule

FILE: rtl/adq_ctrl.sv
// Controller: sequences one word through the datapath and owns the result handshake.
`timescale 1ns / 1ps

module adq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output adq_pkg::cmd_t cmd
);
	import adq_pkg::*;

	localparam int CNT_W = $clog2(TGT_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_TGT  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free_w;

	assign slot_free_w = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.tgt = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == '0) state_d = ST_FIN;
			end
			ST_FIN: begin
				// Hold the finished word until the result register is free.
				cmd.commit = slot_free_w;
				if (slot_free_w) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.tgt) begin
				cnt_q <= CNT_W'(TGT_W - 1);
			end else if (cmd.div) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: tb/adaptive_differential_dequantizer_unit_test.sv
// Self-checking testbench of the stereo adaptive differential dequantizer.
`timescale 1ns / 1ps

module adaptive_differential_dequantizer_unit_test;
	import adq_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 25;
	localparam int WORD_GOAL   = 1400;
	localparam int WIN_DEPTH   = DEF_MAX_WINDOW;

	// Tracks the decoder state and holds the sample pairs still owed by the block.
	class dequant_tracker;
		typedef struct {
			logic signed [CODE_W-1:0] left;
			logic signed [CODE_W-1:0] right;
		} sample_pair_t;

		logic [VG_W-1:0]          vgain;
		logic signed [PG_W-1:0]   pgain;
		logic [WL_W-1:0]          wlen;
		logic [STEP_W-1:0]        step [2];
		logic signed [CODE_W-1:0] pred [2];
		logic signed [CODE_W-1:0] last [2];
		logic [15:0]              win [2][WIN_DEPTH];
		logic [SUM_W-1:0]         sum [2];
		int                       wpos;
		sample_pair_t             owed_samples [$];
		int                       errors;

		function new();
			vgain  = VG_RESET;
			pgain  = PG_RESET;
			wlen   = WL_RESET;
			wpos   = 0;
			errors = 0;
			for (int c = 0; c < 2; c++) begin
				step[c] = STEP_RESET;
				pred[c] = '0;
				last[c] = '0;
				sum[c]  = '0;
				for (int i = 0; i < WIN_DEPTH; i++)
					win[c][i] = '0;
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_VARIANCE_GAIN: begin
					vgain = data[VG_W-1:0];
				end
				CFG_PREDICTOR_GAIN: begin
					pgain = data;
				end
				CFG_WINDOW_LENGTH: begin
					wlen = data[WL_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic signed [CODE_W-1:0] decode(int ch, logic signed [CODE_W-1:0] code,
				int pos, int len);
			int                       prod;
			int                       q;
			int                       t;
			int                       mag;
			int                       s;
			longint                   wide;
			logic [31:0]              target;
			logic signed [CODE_W-1:0] diff;
			logic signed [CODE_W-1:0] outv;

			prod = int'(code) * int'(step[ch]);
			diff = prod[15:0];
			outv = diff + pred[ch];
			// Division of a signed int truncates toward zero, as the hardware does.
			q = (int'(pgain) * int'(last[ch])) / 32768;
			t = int'(outv) - q;
			pred[ch] = t[15:0];
			last[ch] = outv;

			// The most negative difference keeps its full magnitude of 32768.
			mag = (diff < 0) ? -int'(diff) : int'(diff);
			t = int'(sum[ch]) - int'(win[ch][pos]) + mag;
			sum[ch] = t[SUM_W-1:0];
			win[ch][pos] = mag[15:0];

			wide = longint'(sum[ch]) * longint'(vgain);
			target = wide[31:0];
			s = int'(target >> 15) / len;
			if (s > int'(STEP_MAX))
				s = int'(STEP_MAX);
			if (s < 1)
				s = 1;
			step[ch] = s[STEP_W-1:0];
			return outv;
		endfunction

		function void take_codes(logic signed [CODE_W-1:0] l, logic signed [CODE_W-1:0] r);
			sample_pair_t p;
			int           len;
			int           pos;

			len = int'(wlen);
			if (len < 1)
				len = 1;
			if (len > WIN_DEPTH)
				len = WIN_DEPTH;
			pos = wpos;
			if (pos >= WIN_DEPTH)
				pos = 0;
			p.left  = decode(0, l, pos, len);
			p.right = decode(1, r, pos, len);
			// A position left beyond a shortened window is used once, then wraps.
			pos++;
			if (pos >= len)
				pos = 0;
			wpos = pos;
			owed_samples.push_back(p);
		endfunction

		function void check_samples(logic signed [CODE_W-1:0] l, logic signed [CODE_W-1:0] r);
			sample_pair_t e;

			if (owed_samples.size() == 0) begin
				$error("output word with none expected: out_left %0d out_right %0d", l, r);
				errors++;
				return;
			end
			e = owed_samples.pop_front();
			if (e.left !== l) begin
				$error("out_left: expected %0d, actual %0d", e.left, l);
				errors++;
			end
			if (e.right !== r) begin
				$error("out_right: expected %0d, actual %0d", e.right, r);
				errors++;
			end
		endfunction

		function int pending();
			return owed_samples.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	adq_in_if  codes_if ();
	adq_out_if samples_if ();

	dequant_tracker tracker;
	int             src_idle;
	int             snk_idle;
	int             quiet_cycles;

	adaptive_differential_dequantizer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.codes    (codes_if),
		.samples  (samples_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver side: checks each accepted word, stalls at random, and watches for hangs.
	always @(posedge clk) begin
		if (samples_if.valid && samples_if.ready)
			tracker.check_samples(samples_if.out_left, samples_if.out_right);
		samples_if.ready <= ($urandom_range(99) >= snk_idle);
		if ((codes_if.valid && codes_if.ready) || (samples_if.valid && samples_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("adaptive_differential_dequantizer_unit verification failed");
			$finish;
		end
	end

	task automatic send_word(logic signed [CODE_W-1:0] l, logic signed [CODE_W-1:0] r);
		while ($urandom_range(99) < src_idle) begin
			codes_if.valid <= 1'b0;
			@(posedge clk);
		end
		codes_if.valid      <= 1'b1;
		codes_if.code_left  <= l;
		codes_if.code_right <= r;
		do
			@(posedge clk);
		while (!codes_if.ready);
		tracker.take_codes(l, r);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Lets every owed word come back, then gives the datapath time to settle.
	task automatic wait_idle();
		codes_if.valid <= 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic logic signed [CODE_W-1:0] rand_code();
		int pick;

		pick = $urandom_range(99);
		if (pick < 50)
			return CODE_W'($signed($urandom_range(32)) - 16);
		else if (pick < 65)
			return CODE_W'($signed($urandom_range(2047)) - 1024);
		else if (pick < 80) begin
			case ($urandom_range(3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return 16'sd0;
				default: return -16'sd1;
			endcase
		end
		return CODE_W'($urandom);
	endfunction

	task automatic randomize_config();
		logic [CFG_DATA_W-1:0] vg;
		logic [CFG_DATA_W-1:0] pg;
		logic [CFG_DATA_W-1:0] wl;

		case ($urandom_range(5))
			0: vg = 16'd0;
			1: vg = 16'd32767;
			2: vg = 16'($urandom);
			default: vg = 16'($urandom_range(32767));
		endcase
		case ($urandom_range(5))
			0: pg = 16'h8000;
			1: pg = 16'h7fff;
			2: pg = 16'h0000;
			default: pg = 16'($urandom);
		endcase
		case ($urandom_range(7))
			0: wl = 16'd0;
			1: wl = 16'd1;
			2: wl = 16'd16;
			3: wl = 16'($urandom_range(31));
			default: wl = 16'($urandom_range(16, 1));
		endcase
		write_reg(CFG_VARIANCE_GAIN, vg);
		write_reg(CFG_PREDICTOR_GAIN, pg);
		write_reg(CFG_WINDOW_LENGTH, wl);
	endtask

	initial begin
		int sent;
		int n;

		tracker             = new();
		src_idle            = 38;
		snk_idle            = 47;
		quiet_cycles        = 0;
		arst_n              = 1'b0;
		wr_en               = 1'b0;
		wr_index            = '0;
		wr_data             = '0;
		codes_if.valid      = 1'b0;
		codes_if.code_left  = '0;
		codes_if.code_right = '0;
		samples_if.ready    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero codes keep the step at its floor, then the code extremes.
		send_word(16'sd0, 16'sd0);
		send_word(-16'sd32768, 16'sd32767);
		send_word(-16'sd1, 16'sd1);
		send_word(16'sd1, -16'sd1);
		wait_idle();

		// One-entry window at full gain drives the step up to its ceiling.
		write_reg(CFG_VARIANCE_GAIN, 16'd32767);
		write_reg(CFG_PREDICTOR_GAIN, 16'h8000);
		write_reg(CFG_WINDOW_LENGTH, 16'd1);
		send_word(-16'sd32768, 16'sd32767);
		send_word(-16'sd32768, -16'sd32768);
		send_word(16'sd32767, -16'sd32768);
		send_word(16'sd3, 16'sd2);
		wait_idle();

		// Full window, then shrink it while the position sits past the new length.
		write_reg(CFG_VARIANCE_GAIN, 16'd0);
		write_reg(CFG_PREDICTOR_GAIN, 16'h7fff);
		write_reg(CFG_WINDOW_LENGTH, 16'd16);
		for (int i = 0; i < 10; i++)
			send_word(rand_code(), rand_code());
		wait_idle();
		write_reg(CFG_VARIANCE_GAIN, 16'd20000);
		write_reg(CFG_WINDOW_LENGTH, 16'd3);
		for (int i = 0; i < 3; i++)
			send_word(rand_code(), rand_code());
		wait_idle();

		// Lengths outside the window depth are clamped.
		write_reg(CFG_WINDOW_LENGTH, 16'd0);
		send_word(16'sd100, -16'sd100);
		send_word(16'sd7, 16'sd9);
		wait_idle();
		write_reg(CFG_WINDOW_LENGTH, 16'd31);
		send_word(-16'sd5, 16'sd4);
		send_word(16'sd12, -16'sd12);
		wait_idle();

		sent = 0;
		while (sent < WORD_GOAL) begin
			if (sent >= 2 * WORD_GOAL / 3) begin
				src_idle = 0;
				snk_idle = 0;
			end else if (sent >= WORD_GOAL / 3) begin
				src_idle = 47;
				snk_idle = 38;
			end
			n = $urandom_range(120, 40);
			for (int i = 0; i < n; i++)
				send_word(rand_code(), rand_code());
			sent += n;
			wait_idle();
			if ($urandom_range(3) != 0)
				randomize_config();
		end

		wait_idle();
		if (tracker.errors == 0)
			$display("adaptive_differential_dequantizer_unit verification clean");
		else
			$display("adaptive_differential_dequantizer_unit verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/adq_pkg.sv
rtl/adq_in_if.sv
rtl/adq_out_if.sv
rtl/adq_lane.sv
rtl/adq_dp.sv
rtl/adq_ctrl.sv
rtl/adaptive_differential_dequantizer_unit.sv
tb/adaptive_differential_dequantizer_unit_test.sv
